[src/pbh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbh_pkg
// Shared types and codes of the binary greyscale image header checker.
// ----------------------------------------------------------------------------
package pbh_pkg;

	localparam int SIZE_BITS = 34;
	localparam int NUM_BITS  = 16;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_MAGIC = 3'd1;
	localparam logic [2:0] ERR_SEP   = 3'd2;
	localparam logic [2:0] ERR_OVER  = 3'd3;
	localparam logic [2:0] ERR_TRUNC = 3'd4;
	localparam logic [2:0] ERR_LARGE = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} pbh_in_t;

	typedef struct packed {
		logic                 header_ok;
		logic [2:0]           error_code;
		logic [NUM_BITS-1:0]  image_width;
		logic [NUM_BITS-1:0]  image_height;
		logic [NUM_BITS-1:0]  max_value;
		logic [SIZE_BITS-1:0] header_length;
		logic                 two_byte_pixels;
	} pbh_out_t;

	// Verdict request from the parser to the size check. An error code of
	// ERR_NONE means the header is complete and the image size still has
	// to be checked against the file size.
	typedef struct packed {
		logic [2:0]           err;
		logic [NUM_BITS-1:0]  width;
		logic [NUM_BITS-1:0]  height;
		logic [NUM_BITS-1:0]  maxv;
		logic [SIZE_BITS-1:0] hlen;
		logic                 hlen_hi;
	} pbh_req_t;

endpackage

[src/pgm_binary_header_parser.sv]
`timescale 1ns / 1ps
// Path: once the byte that decides it is accepted, a verdict passes through
// the input register, parse, size check and result stages to the result side.
// Throughput: one byte per cycle while results are taken; only a stalled
// result with a full pipeline behind it holds off the byte channel.
// Reset: file_size returns to 1, the parser waits for the letter P and the
// pipeline empties. No clearing pass; the block takes bytes right away.
// ----------------------------------------------------------------------------
// pgm_binary_header_parser
// Checks the header of a binary greyscale image file, one byte per transfer,
// and reports at most one verdict per file.
// ----------------------------------------------------------------------------
module pgm_binary_header_parser #(
	parameter int COUNT_BITS = 34
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  pbh_pkg::pbh_in_t              byte_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output pbh_pkg::pbh_out_t             result_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pbh_pkg::SIZE_BITS-1:0] cfg_data
);

	logic [pbh_pkg::SIZE_BITS-1:0] file_size_q;
	logic                          req_valid;
	pbh_pkg::pbh_req_t             req;
	logic                          take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= pbh_pkg::SIZE_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			file_size_q <= cfg_data;
		end
	end

	pbh_parse #(
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.file_size  (file_size_q),
		.take       (take),
		.req_valid  (req_valid),
		.req        (req)
	);

	pbh_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req          (req),
		.file_size    (file_size_q),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

[src/pbh_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbh_parse
// Input register and header state machine. Each byte updates the parse
// state in one step; a byte that ends the header or fails it leaves a
// verdict request in the stage-two register.
// ----------------------------------------------------------------------------
module pbh_parse #(
	parameter int COUNT_BITS = 34
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  pbh_pkg::pbh_in_t                  byte_data,
	input  logic [pbh_pkg::SIZE_BITS-1:0]     file_size,
	input  logic                              take,
	output logic                              req_valid,
	output pbh_pkg::pbh_req_t                 req
);

	localparam int CMP_W = (COUNT_BITS > pbh_pkg::SIZE_BITS) ? COUNT_BITS
		: pbh_pkg::SIZE_BITS + 1;

	typedef enum logic [3:0] {
		PH_P, PH_5, PH_SEP0, PH_SKIP_W, PH_WIDTH, PH_SKIP_H, PH_HEIGHT,
		PH_SKIP_M, PH_MAX, PH_DONE
	} phase_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'd48) && (b <= 8'd57);
	endfunction

	phase_t                  phase_q, ph, ph_n;
	logic [COUNT_BITS-1:0]   count_q, cnt, cnt_n;
	logic [15:0]             acc_q, acc, acc_n;
	logic [15:0]             width_q, wd, wd_n;
	logic [15:0]             height_q, ht, ht_n;
	logic                    v_s1;
	pbh_pkg::pbh_in_t        in_s1;
	logic                    v_s2;
	pbh_pkg::pbh_req_t       req_s2, req_n;
	logic                    en_s1, en_s2, fire;
	logic                    active, ws, dg, fin, emit;
	logic [2:0]              err;
	logic [15:0]             acc_base;
	logic [19:0]             digit_sum;
	logic [CMP_W-1:0]        cnt_ext;

	assign en_s2      = !v_s2 || take;
	assign en_s1      = !v_s1 || en_s2;
	assign byte_stall = !en_s1;
	assign fire       = v_s1 && en_s2;
	assign req_valid  = v_s2;
	assign req        = req_s2;

	always_comb begin
		ph    = in_s1.frame_start ? PH_P : phase_q;
		cnt   = in_s1.frame_start ? '0 : count_q;
		acc   = in_s1.frame_start ? '0 : acc_q;
		wd    = in_s1.frame_start ? '0 : width_q;
		ht    = in_s1.frame_start ? '0 : height_q;
		active = (ph != PH_DONE);
		cnt_n = active ? cnt + COUNT_BITS'(1) : cnt;
		ph_n  = ph;
		acc_n = acc;
		wd_n  = wd;
		ht_n  = ht;
		err   = pbh_pkg::ERR_NONE;
		fin   = 1'b0;
		ws    = is_ws(in_s1.data_byte);
		dg    = is_digit(in_s1.data_byte);
		// A number's first digit starts from an empty accumulator.
		acc_base  = ((ph == PH_SKIP_W) || (ph == PH_SKIP_H) || (ph == PH_SKIP_M))
			? 16'd0 : acc;
		digit_sum = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
			+ {16'd0, in_s1.data_byte[3:0]};
		unique case (ph)
			PH_P: begin
				if (in_s1.data_byte == 8'h50) ph_n = PH_5;
				else err = pbh_pkg::ERR_MAGIC;
			end
			PH_5: begin
				if (in_s1.data_byte == 8'h35) ph_n = PH_SEP0;
				else err = pbh_pkg::ERR_MAGIC;
			end
			PH_SEP0: begin
				if (ws) ph_n = PH_SKIP_W;
				else err = pbh_pkg::ERR_SEP;
			end
			PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
				if (dg) begin
					acc_n = digit_sum[15:0];
					ph_n  = phase_t'(ph + 4'd1);
				end else if (!ws) begin
					err = pbh_pkg::ERR_SEP;
				end
			end
			PH_WIDTH, PH_HEIGHT, PH_MAX: begin
				if (dg) begin
					if (|digit_sum[19:16]) err = pbh_pkg::ERR_OVER;
					else acc_n = digit_sum[15:0];
				end else if (ws) begin
					if (ph == PH_WIDTH) wd_n = acc;
					if (ph == PH_HEIGHT) ht_n = acc;
					if (ph == PH_MAX) fin = 1'b1;
					else acc_n = '0;
					ph_n = phase_t'(ph + 4'd1);
				end else begin
					err = pbh_pkg::ERR_SEP;
				end
			end
			default: begin
			end
		endcase
		cnt_ext = CMP_W'(cnt_n);
		if (active && !fin && (err == pbh_pkg::ERR_NONE)
			&& (cnt_ext >= CMP_W'(file_size)))
			err = pbh_pkg::ERR_TRUNC;
		emit = active && (fin || (err != pbh_pkg::ERR_NONE));
		if (emit) ph_n = PH_DONE;
		req_n.err     = err;
		req_n.width   = wd;
		req_n.height  = ht;
		req_n.maxv    = acc;
		req_n.hlen    = cnt_ext[pbh_pkg::SIZE_BITS-1:0];
		req_n.hlen_hi = |cnt_ext[CMP_W-1:pbh_pkg::SIZE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_P;
			count_q  <= '0;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			v_s1     <= 1'b0;
			in_s1    <= '0;
			v_s2     <= 1'b0;
			req_s2   <= '0;
		end else begin
			if (byte_valid && en_s1) begin
				v_s1  <= 1'b1;
				in_s1 <= byte_data;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (fire) begin
				phase_q  <= ph_n;
				count_q  <= cnt_n;
				acc_q    <= acc_n;
				width_q  <= wd_n;
				height_q <= ht_n;
			end
			if (en_s2) begin
				v_s2   <= fire && emit;
				req_s2 <= req_n;
			end
		end
	end

`ifndef SYNTH
	// A request that the size check has not taken must stay put.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !take |=> v_s2 && $stable(req_s2))
		else $error("verdict request changed while waiting");
`endif

endmodule

[src/pbh_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbh_check
// Image size check and result register. One stage forms width times height
// and the bytes left after the header; the next compares them and builds
// the verdict.
// ----------------------------------------------------------------------------
module pbh_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  pbh_pkg::pbh_req_t                 req,
	input  logic [pbh_pkg::SIZE_BITS-1:0]     file_size,
	output logic                              take,
	output logic                              result_valid,
	input  logic                              result_stall,
	output pbh_pkg::pbh_out_t                 result_data
);

	logic                              v_s3;
	logic [2:0]                        err_s3;
	logic [15:0]                       w_s3, h_s3, m_s3;
	logic [pbh_pkg::SIZE_BITS-1:0]     hlen_s3, rem_s3;
	logic [31:0]                       prod_s3, prod_c;
	logic                              big_s3;
	logic [pbh_pkg::SIZE_BITS:0]       diff_c;
	logic [32:0]                       img_c;
	logic                              two_c, large_c;
	logic                              out_v_q;
	pbh_pkg::pbh_out_t                 out_q, out_n;
	logic                              en_out;

	assign en_out = !out_v_q || !result_stall;
	assign take   = !v_s3 || en_out;

	assign prod_c = 32'(req.width) * 32'(req.height);
	assign diff_c = {1'b0, file_size} - {1'b0, req.hlen};

	always_comb begin
		two_c   = (m_s3 >= 16'd256);
		img_c   = two_c ? {prod_s3, 1'b0} : {1'b0, prod_s3};
		large_c = big_s3 || ({1'b0, img_c} > rem_s3);
		out_n   = '0;
		if (err_s3 != pbh_pkg::ERR_NONE) begin
			out_n.error_code = err_s3;
		end else if (large_c) begin
			out_n.error_code = pbh_pkg::ERR_LARGE;
		end else begin
			out_n.header_ok       = 1'b1;
			out_n.error_code      = pbh_pkg::ERR_NONE;
			out_n.image_width     = w_s3;
			out_n.image_height    = h_s3;
			out_n.max_value       = m_s3;
			out_n.header_length   = hlen_s3;
			out_n.two_byte_pixels = two_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			err_s3  <= pbh_pkg::ERR_NONE;
			w_s3    <= '0;
			h_s3    <= '0;
			m_s3    <= '0;
			hlen_s3 <= '0;
			rem_s3  <= '0;
			prod_s3 <= '0;
			big_s3  <= 1'b0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (take) begin
				v_s3    <= req_valid;
				err_s3  <= req.err;
				w_s3    <= req.width;
				h_s3    <= req.height;
				m_s3    <= req.maxv;
				hlen_s3 <= req.hlen;
				rem_s3  <= diff_c[pbh_pkg::SIZE_BITS-1:0];
				// The header alone overruns the file when the count has
				// bits above the size width or the difference went negative.
				big_s3  <= req.hlen_hi || diff_c[pbh_pkg::SIZE_BITS];
				prod_s3 <= prod_c;
			end
			if (en_out) begin
				out_v_q <= v_s3;
				out_q   <= out_n;
			end
		end
	end

	assign result_valid = out_v_q;
	assign result_data  = out_q;

`ifndef SYNTH
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.header_ok |->
		result_data.image_width == 16'd0 && result_data.image_height == 16'd0
		&& result_data.max_value == 16'd0 && result_data.header_length == '0
		&& !result_data.two_byte_pixels)
		else $error("failed verdict carries parsed values");
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		result_data.header_ok == (result_data.error_code == pbh_pkg::ERR_NONE))
		else $error("header_ok disagrees with error code");
	a_two_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.header_ok |->
		result_data.two_byte_pixels == (result_data.max_value >= 16'd256))
		else $error("pixel size flag disagrees with max value");
	a_s3_move: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !take |=> v_s3 && $stable(err_s3) && $stable(prod_s3))
		else $error("size check stage lost its item");
`endif

endmodule

[sim/tb_pgm_binary_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pgm_binary_header_parser
// Self-checking bench for the image header checker. It streams directed and
// random headers under several flow-control mixes and predicts every verdict.
// Each verdict is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module tb_pgm_binary_header_parser;

	localparam int SIZE_W         = pbh_pkg::SIZE_BITS;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_ITEMS    = 110;
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	typedef enum logic [3:0] {
		WAIT_P, WAIT_5, WAIT_SEP, SKIP_W, IN_W, SKIP_H, IN_H, SKIP_M, IN_M, DONE
	} hdr_phase_t;

	class header_scoreboard;
		logic [SIZE_W-1:0]  file_size;
		hdr_phase_t         phase;
		logic [SIZE_W-1:0]  byte_count;
		int unsigned        acc;
		int unsigned        width;
		int unsigned        height;
		int unsigned        maxv;
		pbh_pkg::pbh_out_t  verdicts[$];
		int                 errors;
		int                 checked;
		int                 parsed;

		function new();
			file_size = SIZE_W'(1);
			errors = 0;
			checked = 0;
			parsed = 0;
			clear();
		endfunction

		function void clear();
			phase = WAIT_P;
			byte_count = '0;
			acc = 0;
			width = 0;
			height = 0;
			maxv = 0;
		endfunction

		function void set_size(logic [SIZE_W-1:0] v);
			file_size = v;
		endfunction

		function void push_verdict(logic [2:0] err, logic [SIZE_W-1:0] hlen);
			pbh_pkg::pbh_out_t v;
			v = '0;
			v.error_code = err;
			if (err == pbh_pkg::ERR_NONE) begin
				v.header_ok = 1'b1;
				v.image_width = width[15:0];
				v.image_height = height[15:0];
				v.max_value = maxv[15:0];
				v.header_length = hlen;
				v.two_byte_pixels = (maxv >= 256);
			end
			verdicts.push_back(v);
			phase = DONE;
		endfunction

		function logic [2:0] add_digit(logic [7:0] b);
			int unsigned v;
			v = acc * 10 + (b - 8'd48);
			if (v > 32'hffff)
				return pbh_pkg::ERR_OVER;
			acc = v;
			return pbh_pkg::ERR_NONE;
		endfunction

		// The image must fit in what is left of the file after the header.
		function void finish_header();
			longint unsigned hlen;
			longint unsigned img;
			longint unsigned fsz;
			hlen = byte_count;
			fsz = file_size;
			img = longint'((maxv >= 256) ? 2 : 1) * longint'(width)
				* longint'(height);
			if (hlen > fsz || img > fsz - hlen)
				push_verdict(pbh_pkg::ERR_LARGE, '0);
			else
				push_verdict(pbh_pkg::ERR_NONE, hlen[SIZE_W-1:0]);
		endfunction

		function void note_byte(pbh_pkg::pbh_in_t it);
			logic [7:0] b;
			logic [2:0] err;
			bit         ws;
			bit         dg;
			b = it.data_byte;
			if (it.frame_start)
				clear();
			if (phase == DONE)
				return;
			parsed++;
			byte_count = byte_count + 1'b1;
			ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
			dg = (b >= "0") && (b <= "9");
			err = pbh_pkg::ERR_NONE;
			case (phase)
				WAIT_P: if (b == "P") phase = WAIT_5; else err = pbh_pkg::ERR_MAGIC;
				WAIT_5: if (b == "5") phase = WAIT_SEP; else err = pbh_pkg::ERR_MAGIC;
				WAIT_SEP: if (ws) phase = SKIP_W; else err = pbh_pkg::ERR_SEP;
				SKIP_W, SKIP_H, SKIP_M: begin
					if (dg) begin
						acc = 0;
						err = add_digit(b);
						phase = hdr_phase_t'(phase + 1);
					end else if (!ws) begin
						err = pbh_pkg::ERR_SEP;
					end
				end
				IN_W, IN_H: begin
					if (dg) begin
						err = add_digit(b);
					end else if (ws) begin
						if (phase == IN_W)
							width = acc;
						else
							height = acc;
						acc = 0;
						phase = hdr_phase_t'(phase + 1);
					end else begin
						err = pbh_pkg::ERR_SEP;
					end
				end
				IN_M: begin
					if (dg) begin
						err = add_digit(b);
					end else if (ws) begin
						maxv = acc;
						finish_header();
						return;
					end else begin
						err = pbh_pkg::ERR_SEP;
					end
				end
				default: ;
			endcase
			// An error raised by the byte itself wins over running out of file.
			if (err != pbh_pkg::ERR_NONE)
				push_verdict(err, '0);
			else if (byte_count >= file_size)
				push_verdict(pbh_pkg::ERR_TRUNC, '0);
		endfunction

		function void cmp(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(pbh_pkg::pbh_out_t got);
			pbh_pkg::pbh_out_t want;
			if (verdicts.size() == 0) begin
				$display("%0t: verdict with none expected, expected nothing, actual %p",
					$time, got);
				errors++;
				return;
			end
			want = verdicts.pop_front();
			checked++;
			cmp("header_ok", want.header_ok, got.header_ok);
			cmp("error_code", want.error_code, got.error_code);
			cmp("image_width", want.image_width, got.image_width);
			cmp("image_height", want.image_height, got.image_height);
			cmp("max_value", want.max_value, got.max_value);
			cmp("header_length", want.header_length, got.header_length);
			cmp("two_byte_pixels", want.two_byte_pixels, got.two_byte_pixels);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	pbh_pkg::pbh_in_t   byte_data = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	pbh_pkg::pbh_out_t  result_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SIZE_W-1:0]  cfg_data = '0;

	header_scoreboard board = new();

	int send_pct = 0;
	int recv_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet = 0;
	int files_sent = 0;
	int items_sent = 0;
	int cfg_writes = 0;

	pbh_pkg::pbh_in_t   file_items[$];
	int                 fhdr_len;
	int unsigned        fw;
	int unsigned        fh;
	int unsigned        fm;
	logic [SIZE_W-1:0]  cur_size = SIZE_W'(1);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pgm_binary_header_parser #(
		.COUNT_BITS(34)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Result side: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(result_data);
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(pbh_pkg::pbh_in_t it);
		while ($urandom_range(0, 99) < send_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		items_sent++;
		board.note_byte(it);
	endtask

	task automatic send_text(string s, logic first_fs);
		pbh_pkg::pbh_in_t it;
		files_sent++;
		for (int i = 0; i < s.len(); i++) begin
			it.data_byte = s[i];
			it.frame_start = (i == 0) ? first_fs : 1'b0;
			send_item(it);
		end
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (board.verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.set_size(v);
		cur_size = v;
		cfg_writes++;
	endtask

	task automatic set_mode(int mode);
		case (mode)
			0: begin send_pct = 0;  recv_pct = 0;  end
			1: begin send_pct = 49; recv_pct = 0;  end
			2: begin send_pct = 0;  recv_pct = 49; end
			default: begin send_pct = 26; recv_pct = 26; end
		endcase
	endtask

	function automatic void push_byte(logic [7:0] b);
		pbh_pkg::pbh_in_t it;
		it = '{data_byte: b, frame_start: 1'b0};
		file_items.push_back(it);
	endfunction

	function automatic logic [7:0] ws_byte();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? 8'd32 : 8'(9 + k);
	endfunction

	function automatic void push_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
		repeat (n) push_byte(ws_byte());
	endfunction

	function automatic void push_number(int unsigned v);
		string s;
		int    zeros;
		zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (zeros) push_byte("0");
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	// Well-formed header with up to three pixel bytes after it.
	function automatic void build_header(int unsigned w, int unsigned h, int unsigned m);
		file_items.delete();
		push_byte("P");
		push_byte("5");
		push_gap();
		push_number(w);
		push_gap();
		push_number(h);
		push_gap();
		push_number(m);
		push_byte(ws_byte());
		fhdr_len = file_items.size();
		fw = w;
		fh = h;
		fm = m;
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
		file_items[0].frame_start = 1'b1;
	endfunction

	function automatic int unsigned pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 12);
		if (r < 90)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	function automatic int unsigned pick_max();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 255;
		if (r < 20)
			return 256;
		if (r < 28)
			return 65535;
		if (r < 34)
			return 0;
		if (r < 60)
			return $urandom_range(0, 255);
		return $urandom_range(0, 65535);
	endfunction

	task automatic random_file();
		int          r;
		int          idx;
		int unsigned w;
		int unsigned h;
		int unsigned m;
		r = $urandom_range(0, 99);
		if (r < 90) begin
			w = pick_dim();
			h = pick_dim();
			m = pick_max();
			if (r >= 72 && r < 80) begin
				case ($urandom_range(0, 2))
					0: w = $urandom_range(65536, 999999);
					1: h = $urandom_range(65536, 999999);
					default: m = $urandom_range(65536, 999999);
				endcase
			end
			build_header(w, h, m);
			if (r >= 60 && r < 72) begin
				idx = $urandom_range(0, fhdr_len - 1);
				file_items[idx].data_byte = 8'($urandom);
			end else if (r >= 80) begin
				// Cut short: the next frame start has to restart the parser.
				idx = $urandom_range(1, fhdr_len - 1);
				file_items = file_items[0:idx-1];
			end
			if ($urandom_range(0, 19) == 0)
				file_items[0].frame_start = 1'b0;
		end else begin
			file_items.delete();
			repeat ($urandom_range(1, 6)) begin
				push_byte(8'($urandom));
				file_items[file_items.size()-1].frame_start = 1'($urandom_range(0, 1));
			end
		end
		files_sent++;
		foreach (file_items[i])
			send_item(file_items[i]);
	endtask

	// The file size is lowered just before the byte that completes the header,
	// to one byte under the header or at or just below header plus image.
	task automatic resize_check();
		longint unsigned    img;
		logic [SIZE_W-1:0]  keep;
		logic [SIZE_W-1:0]  tight;
		keep = cur_size;
		build_header($urandom_range(0, 12), $urandom_range(0, 12), pick_max());
		files_sent++;
		for (int i = 0; i < fhdr_len - 1; i++)
			send_item(file_items[i]);
		drain();
		img = longint'((fm >= 256) ? 2 : 1) * longint'(fw) * longint'(fh);
		case ($urandom_range(0, 2))
			0: tight = SIZE_W'(fhdr_len - 1);
			1: tight = SIZE_W'(longint'(fhdr_len) + img - 1);
			default: tight = SIZE_W'(longint'(fhdr_len) + img);
		endcase
		write_size(tight);
		send_item(file_items[fhdr_len-1]);
		drain();
		write_size(keep);
	endtask

	initial begin
		int                 target;
		logic [SIZE_W-1:0]  sz;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size is one byte, so a good first letter is already truncated.
		send_text("P", 1'b0);
		drain();
		write_size(SIZE_MAX);
		send_text("Q", 1'b1);
		send_text("P6", 1'b1);
		send_text("P5x", 1'b1);
		send_text("P5 65536", 1'b1);
		send_text("P5\t1 1 65535\nZ", 1'b1);

		for (int ph = 0; ph < 12; ph++) begin
			set_mode(ph % 4);
			case (ph % 6)
				0: sz = SIZE_MAX;
				1: sz = SIZE_W'($urandom_range(8, 40));
				2: sz = SIZE_W'($urandom_range(40, 600));
				3: sz = SIZE_W'(1);
				4: sz = {2'($urandom), 32'($urandom)};
				default: sz = SIZE_W'($urandom_range(600, 200000));
			endcase
			drain();
			write_size(sz);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_file();
			if (sz == SIZE_MAX)
				repeat (3) resize_check();
		end

		// Long hold-off on the result side while single-byte files keep coming.
		drain();
		set_mode(0);
		write_size(SIZE_MAX);
		hold_requests <= hold_requests + 1;
		repeat (40) send_item('{data_byte: "Z", frame_start: 1'b1});
		drain();

		if (board.verdicts.size() != 0)
			$display("%0t: %0d expected verdicts never arrived, expected 0, actual %0d",
				$time, board.verdicts.size(), board.verdicts.size());
		$display("Checked %0d verdicts over %0d files, %0d bytes sent, %0d parsed, %0d size writes.",
			board.checked, files_sent, items_sent, board.parsed, cfg_writes);
		$display("Covered every error kind, sizes from one byte to the maximum, and four stall mixes.");
		if (board.errors == 0 && board.verdicts.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[pgm_binary_header_parser.f]
src/pbh_pkg.sv
src/pbh_parse.sv
src/pbh_check.sv
src/pgm_binary_header_parser.sv
sim/tb_pgm_binary_header_parser.sv
